// ===== rtl/mmcn_pkg.sv =====
// Shared types and constants for the magnetometer calibrate/normalize block.
package mmcn_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 14;
    localparam int UNIT_FRAC       = 14;
    localparam int FIELD_W         = 16;
    localparam int CFG_W           = 16;
    localparam int COUNT_W         = 16;
    localparam logic [CFG_W-1:0] QUEUE_FRAME_RESET = 16'd400;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_RECAL  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, run bounds update
        logic div_start;  // start one axis divide
        logic [1:0] axis; // axis of divide
        logic div_unit;   // 0: axis map divide, 1: unit divide
        logic sqrt_start;
        logic out_load;   // latch result word
    } mmcn_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_recal;
        logic bounds_ok;
        logic len_zero;
        logic div_done;
        logic sqrt_done;
    } mmcn_status_t;

endpackage

// ===== rtl/mmcn_ctrl.sv =====
// Sequencer for the calibrate/normalize datapath.
module mmcn_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  mmcn_pkg::mmcn_status_t st,
    output mmcn_pkg::mmcn_cmd_t   cmd
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_MAP   = 7'b0000100,
        S_SQRT  = 7'b0001000,
        S_UNIT  = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic go_reg, go_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        go_next    = 1'b0;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (st.is_recal || !st.bounds_ok) begin
                    state_next = S_DONE;
                end else begin
                    axis_next  = 2'd0;
                    go_next    = 1'b1;
                    state_next = S_MAP;
                end
            end
            S_MAP: begin
                cmd.div_start = go_reg;
                if (!go_reg && st.div_done) begin
                    if (axis_reg == 2'd2) begin
                        go_next    = 1'b1;
                        state_next = S_SQRT;
                    end else begin
                        axis_next = axis_reg + 2'd1;
                        go_next   = 1'b1;
                    end
                end
            end
            S_SQRT: begin
                cmd.sqrt_start = go_reg;
                if (!go_reg && st.sqrt_done) begin
                    if (st.len_zero) begin
                        state_next = S_DONE;
                    end else begin
                        axis_next  = 2'd0;
                        go_next    = 1'b1;
                        state_next = S_UNIT;
                    end
                end
            end
            S_UNIT: begin
                cmd.div_unit  = 1'b1;
                cmd.div_start = go_reg;
                if (!go_reg && st.div_done) begin
                    if (axis_reg == 2'd2) begin
                        state_next = S_DONE;
                    end else begin
                        axis_next = axis_reg + 2'd1;
                        go_next   = 1'b1;
                    end
                end
            end
            S_DONE: begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            axis_reg  <= 2'd0;
            go_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            go_reg    <= go_next;
        end
    end
endmodule

// ===== rtl/mmcn_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module mmcn_div #(
    parameter int W = 40
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic [W-1:0] quo,
    output logic         done
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  q_reg, q_next, d_reg, d_next;
    logic [W:0]    r_reg, r_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;

    assign quo  = q_reg;
    assign done = !busy_reg;

    always_comb begin
        q_next    = q_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[W-1:0], q_reg[W-1]};
        if (start) begin
            q_next    = num;
            d_next    = den;
            r_next    = '0;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        d_reg <= d_next;
        r_reg <= r_next;
    end
endmodule

// ===== rtl/mmcn_sqrt.sv =====
// Bit-pair integer square root, one result bit per cycle.
module mmcn_sqrt #(
    parameter int W = 46
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   n,
    output logic [W/2-1:0] root,
    output logic           done
);
    localparam int H  = (W + 1) / 2;
    localparam int CW = $clog2(H + 1);
    logic [2*H-1:0] n_reg, n_next;
    logic [H+1:0]   r_reg, r_next;
    logic [H-1:0]   q_reg, q_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [H+1:0]   trial, test;

    assign root = q_reg[W/2-1:0];
    assign done = !busy_reg;

    always_comb begin
        n_next    = n_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[H-1:0], n_reg[2*H-1 -: 2]};
        test      = {q_reg, 2'b01};
        if (start) begin
            n_next    = (2*H)'(n);
            r_next    = '0;
            q_next    = '0;
            cnt_next  = CW'(H);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            n_next = {n_reg[2*H-3:0], 2'b00};
            if (trial >= test) begin
                r_next = trial - test;
                q_next = {q_reg[H-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[H-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        n_reg <= n_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end
endmodule

// ===== rtl/mmcn_datapath.sv =====
// Bounds tracking, axis mapping, length and unit-vector datapath.
module mmcn_datapath #(
    parameter int SAMPLE_BITS = mmcn_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = mmcn_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mmcn_pkg::mmcn_cmd_t                 cmd,
    output mmcn_pkg::mmcn_status_t              st,
    input  logic                                in_cmd,
    input  logic signed [mmcn_pkg::FIELD_W-1:0] in_x,
    input  logic signed [mmcn_pkg::FIELD_W-1:0] in_y,
    input  logic signed [mmcn_pkg::FIELD_W-1:0] in_z,
    input  logic [mmcn_pkg::CFG_W-1:0]          queue_frame,
    output logic [1:0]                          out_user, // data_valid, swapped
    output logic [6*mmcn_pkg::FIELD_W-1:0]      out_data  // raw_x..raw_z, unit_x..unit_z
);
    localparam int SB   = SAMPLE_BITS;
    localparam int FW   = mmcn_pkg::FIELD_W;
    localparam int UF   = mmcn_pkg::UNIT_FRAC;
    localparam int VW   = FRAC_BITS + 2;           // signed axis value width
    localparam int SQW  = 2 * (FRAC_BITS + 1) + 2; // length squared width
    localparam int RW   = SQW / 2;
    localparam int DW0  = SB + 1 + FRAC_BITS + 3;
    localparam int DW1  = (FRAC_BITS + 1) + UF + 2;
    localparam int DW   = (DW0 > DW1) ? DW0 : DW1;
    localparam int CNTW = mmcn_pkg::COUNT_W;
    localparam logic signed [SB-1:0] LOW_INIT  = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] HIGH_INIT = {1'b1, {(SB-1){1'b0}}};

    logic signed [SB-1:0] blo_reg [3], bhi_reg [3], plo_reg [3], phi_reg [3];
    logic signed [SB-1:0] blo_next[3], bhi_next[3], plo_next[3], phi_next[3];
    logic signed [SB-1:0] s_reg [3];
    logic signed [VW-1:0] v_reg [3];
    logic [FW-1:0]        u_reg [3];
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic                 recal_reg, ok_reg, swap_reg, swap_next, ok_next;
    logic [RW-1:0]        root_reg;
    logic [SQW-1:0]       len2;
    logic signed [2*VW-1:0] sq;
    logic signed [SB-1:0] s_in [3];
    logic                 bvalid_new, bvalid, pvalid, do_swap;
    logic [SB+2:0]        err_a, err_b;

    // low SAMPLE_BITS bits of each field are the reading
    assign s_in[0] = SB'($unsigned(in_x));
    assign s_in[1] = SB'($unsigned(in_y));
    assign s_in[2] = SB'($unsigned(in_z));

    always_comb begin
        bvalid = 1'b1;
        pvalid = 1'b1;
        err_a  = '0;
        err_b  = '0;
        for (int i = 0; i < 3; i++) begin
            bvalid = bvalid && (bhi_reg[i] > blo_reg[i]);
            pvalid = pvalid && (phi_reg[i] > plo_reg[i]);
            err_a  = err_a + (SB+3)'({{3{bhi_reg[i][SB-1]}}, bhi_reg[i]}
                                   - {{3{blo_reg[i][SB-1]}}, blo_reg[i]});
            err_b  = err_b + (SB+3)'({{3{phi_reg[i][SB-1]}}, phi_reg[i]}
                                   - {{3{plo_reg[i][SB-1]}}, plo_reg[i]});
        end
        do_swap = bvalid && pvalid && (err_b < err_a);
    end

    always_comb begin
        bvalid_new = 1'b1;
        cnt_next   = cnt_reg;
        swap_next  = 1'b0;
        ok_next    = 1'b0;
        for (int i = 0; i < 3; i++) begin
            blo_next[i] = blo_reg[i];
            bhi_next[i] = bhi_reg[i];
            plo_next[i] = plo_reg[i];
            phi_next[i] = phi_reg[i];
        end
        if (in_cmd == mmcn_pkg::CMD_RECAL) begin
            if (bvalid && pvalid) begin
                for (int i = 0; i < 3; i++) begin
                    if (do_swap) begin
                        blo_next[i] = plo_reg[i];
                        bhi_next[i] = phi_reg[i];
                    end
                    plo_next[i] = LOW_INIT;
                    phi_next[i] = HIGH_INIT;
                end
                if (do_swap) cnt_next = '0;
                swap_next = do_swap;
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (s_in[i] < blo_reg[i]) blo_next[i] = s_in[i];
                if (s_in[i] > bhi_reg[i]) bhi_next[i] = s_in[i];
                bvalid_new = bvalid_new && (bhi_next[i] > blo_next[i]);
            end
            if (bvalid_new) begin
                ok_next = 1'b1;
                if (cnt_reg != {CNTW{1'b1}}) cnt_next = cnt_reg + CNTW'(1);
                if (cnt_next > queue_frame) begin
                    for (int i = 0; i < 3; i++) begin
                        if (s_in[i] < plo_reg[i]) plo_next[i] = s_in[i];
                        if (s_in[i] > phi_reg[i]) phi_next[i] = s_in[i];
                    end
                end
            end
        end
    end

    // shared divider
    logic [DW-1:0] dnum, dden, dquo;
    logic          ddone;
    logic [SB:0]   dd, span;
    logic [VW-1:0] av;

    always_comb begin
        dd   = (SB+1)'({s_reg[cmd.axis][SB-1], s_reg[cmd.axis]}
                     - {blo_reg[cmd.axis][SB-1], blo_reg[cmd.axis]});
        span = (SB+1)'({bhi_reg[cmd.axis][SB-1], bhi_reg[cmd.axis]}
                     - {blo_reg[cmd.axis][SB-1], blo_reg[cmd.axis]});
        av   = v_reg[cmd.axis][VW-1] ? -v_reg[cmd.axis] : v_reg[cmd.axis];
        if (cmd.div_unit) begin
            dnum = DW'({av, {(UF+1){1'b0}}}) + DW'(root_reg);
            dden = DW'({root_reg, 1'b0});
        end else begin
            dnum = DW'({dd, {(FRAC_BITS+2){1'b0}}}) + DW'(span);
            dden = DW'({span, 1'b0});
        end
    end

    mmcn_div #(.W(DW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(dnum), .den(dden), .quo(dquo), .done(ddone)
    );

    always_comb begin
        len2 = '0;
        for (int i = 0; i < 3; i++) begin
            sq   = v_reg[i] * v_reg[i];
            len2 = len2 + SQW'($unsigned(sq));
        end
    end

    // sum of squares registered ahead of the root
    logic [SQW-1:0] len2_reg;
    logic [RW-1:0]  root;
    logic           sdone;

    mmcn_sqrt #(.W(SQW)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.sqrt_start),
        .n(len2_reg), .root(root), .done(sdone)
    );

    logic div_pend_reg, sq_pend_reg;

    // capture divider result once when it finishes
    logic div_capture, div_armed_reg;
    assign div_capture = ddone && div_armed_reg && !div_pend_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) div_armed_reg <= 1'b0;
        else if (div_pend_reg)  div_armed_reg <= 1'b1;
        else if (div_capture)   div_armed_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                blo_reg[i] <= LOW_INIT;
                bhi_reg[i] <= HIGH_INIT;
                plo_reg[i] <= LOW_INIT;
                phi_reg[i] <= HIGH_INIT;
            end
            cnt_reg      <= '0;
            div_pend_reg <= 1'b0;
            sq_pend_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                for (int i = 0; i < 3; i++) begin
                    blo_reg[i] <= blo_next[i];
                    bhi_reg[i] <= bhi_next[i];
                    plo_reg[i] <= plo_next[i];
                    phi_reg[i] <= phi_next[i];
                end
                cnt_reg <= cnt_next;
            end
            div_pend_reg <= cmd.div_start;
            sq_pend_reg  <= cmd.sqrt_start;
        end
        len2_reg <= len2;
        if (cmd.load) begin
            recal_reg <= in_cmd;
            ok_reg    <= ok_next;
            swap_reg  <= swap_next;
            for (int i = 0; i < 3; i++) begin
                s_reg[i] <= s_in[i];
                v_reg[i] <= '0;
                u_reg[i] <= '0;
            end
        end
        if (div_capture) begin
            if (cmd.div_unit)
                u_reg[cmd.axis] <= v_reg[cmd.axis][VW-1]
                    ? FW'(-$signed({1'b0, dquo[FW-1:0]})) : dquo[FW-1:0];
            else
                v_reg[cmd.axis] <= VW'(dquo) - VW'(1 << FRAC_BITS);
        end
        if (sdone && !sq_pend_reg) root_reg <= root;
    end

    assign st.is_recal  = recal_reg;
    assign st.bounds_ok = ok_reg;
    assign st.len_zero  = (root == '0);
    assign st.div_done  = ddone && !div_pend_reg && !div_armed_reg;
    assign st.sqrt_done = sdone && !sq_pend_reg;

    logic [FW-1:0] rx, ry, rz;
    assign rx = ok_reg ? FW'(s_reg[0]) : '0;
    assign ry = ok_reg ? FW'(s_reg[1]) : '0;
    assign rz = ok_reg ? FW'(s_reg[2]) : '0;

    // result register, held while the receiver stalls
    logic [1:0]      user_reg;
    logic [6*FW-1:0] data_reg;
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            user_reg <= {swap_reg, ok_reg};
            data_reg <= {u_reg[2], u_reg[1], u_reg[0], rz, ry, rx};
        end
    end
    assign out_user = user_reg;
    assign out_data = data_reg;
endmodule

// ===== rtl/mag_min_max_calibrate_normalize.sv =====
// Top level: magnetometer hard-iron min/max calibration and unit-vector output.
//
// One request is taken at a time; the block returns exactly one result per request.
// With a receiver that is always ready, a recalibrate request or a sample that leaves
// the bounds invalid passes from accept to next accept through idle, check, done and
// result. A calibrated sample also runs, between check and done, three axis maps on
// the shared bit-serial divider (34-bit quotient at default widths), a bit-pair square
// root and three unit divides on the same divider. A zero-length vector skips the unit
// divides. Receiver stalls hold the block in the result state.
module mag_min_max_calibrate_normalize #(
    parameter int SAMPLE_BITS = mmcn_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = mmcn_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // mag_x, mag_y, mag_z
    input  logic         s_tuser,   // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // raw_x, raw_y, raw_z, unit_x, unit_y, unit_z
    output logic [1:0]   m_tuser,   // data_valid, swapped
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);
    mmcn_pkg::mmcn_cmd_t    cmd;
    mmcn_pkg::mmcn_status_t st;
    logic [mmcn_pkg::CFG_W-1:0] qf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) qf_reg <= mmcn_pkg::QUEUE_FRAME_RESET;
        else if (cfg_we) qf_reg <= cfg_wdata;
    end

    mmcn_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .st(st), .cmd(cmd)
    );

    mmcn_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .st(st),
        .in_cmd(s_tuser), .in_x(s_tdata[15:0]), .in_y(s_tdata[31:16]),
        .in_z(s_tdata[47:32]), .queue_frame(qf_reg),
        .out_user(m_tuser), .out_data(m_tdata)
    );

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output both open");
    a_out_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid) else $error("result not presented");
    a_swap_only_recal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> !m_tuser[0]) else $error("swap on sample");
`endif
endmodule
